// ===== hw/rtl/cbts_pkg.sv =====
// ----------------------------------------------------------------------------
// cbts_pkg: shared types and constants for the CAN bit timing solver
// Holds the register map, the configuration and result bundles, the
// sequencer state type and the fixed widths used across the block.
// ----------------------------------------------------------------------------
package cbts_pkg;

	// field widths
	localparam int CLOCK_W    = 29;
	localparam int PRESC_W    = 11;
	localparam int SEG1_W     = 5;
	localparam int SEG2_W     = 4;
	localparam int JW_W       = 3;
	localparam int TQ_W       = 5;
	localparam int POINT_W    = 10;
	localparam int BITRATE_W  = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;

	// datapath widths
	localparam int DIVISOR_W = PRESC_W + BITRATE_W;   // prescaler times bitrate
	localparam int SUB_W     = DIVISOR_W + TQ_W;      // divisor shifted by quotient bits
	localparam int REM_W     = CLOCK_W;
	localparam int STEP_W    = 4;
	localparam int CNT_W     = SEG1_W + 1;            // seg1 counter can pass seg1_max

	// algorithm constants
	localparam int SEG1_MIN = 1;
	localparam int SEG2_MIN = 1;
	localparam int PERMILLE = 1000;
	localparam int TQ_STEPS = TQ_W;                   // quotient bits of clock / divisor
	localparam int SP_STEPS = POINT_W;                // quotient bits of sample point

	// register reset values
	localparam logic [CLOCK_W-1:0] CLOCK_RST    = CLOCK_W'(48000000);
	localparam logic [PRESC_W-1:0] PRESC_MIN_RST = PRESC_W'(1);
	localparam logic [PRESC_W-1:0] PRESC_MAX_RST = PRESC_W'(1024);
	localparam logic [SEG1_W-1:0]  SEG1_MAX_RST  = SEG1_W'(16);
	localparam logic [SEG2_W-1:0]  SEG2_MAX_RST  = SEG2_W'(8);
	localparam logic [JW_W-1:0]    JW_MAX_RST    = JW_W'(4);
	localparam logic [TQ_W-1:0]    TQ_MIN_RST    = TQ_W'(8);
	localparam logic [TQ_W-1:0]    TQ_MAX_RST    = TQ_W'(25);

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOCK_HZ       = 3'd0,
		CFG_PRESCALER_MIN  = 3'd1,
		CFG_PRESCALER_MAX  = 3'd2,
		CFG_SEG1_MAX       = 3'd3,
		CFG_SEG2_MAX       = 3'd4,
		CFG_JUMP_WIDTH_MAX = 3'd5,
		CFG_QUANTA_MIN     = 3'd6,
		CFG_QUANTA_MAX     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CLOCK_W-1:0] clock_hz;
		logic [PRESC_W-1:0] prescaler_min;
		logic [PRESC_W-1:0] prescaler_max;
		logic [SEG1_W-1:0]  seg1_max;
		logic [SEG2_W-1:0]  seg2_max;
		logic [JW_W-1:0]    jump_width_max;
		logic [TQ_W-1:0]    quanta_min;
		logic [TQ_W-1:0]    quanta_max;
	} cfg_t;

	typedef struct packed {
		logic                 found;
		logic [PRESC_W-1:0]   prescaler;
		logic [SEG1_W-1:0]    seg1;
		logic [SEG2_W-1:0]    seg2;
		logic [JW_W-1:0]      jump_width;
		logic [TQ_W-1:0]      quanta_per_bit;
		logic [POINT_W-1:0]   point_achieved;
		logic [BITRATE_W-1:0] bitrate_achieved;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_MUL,
		ST_DIV,
		ST_TQCHK,
		ST_SEG,
		ST_SPDIV,
		ST_EVAL,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/can_bit_timing_solver_top.sv =====
// ----------------------------------------------------------------------------
// can_bit_timing_solver_top: CAN bit timing solver
// Sequence: per prescaler, the product is formed and the quanta count divided
//   out, quitting early when the quotient reaches 32 or the product is zero; an
//   exact prescaler in the quanta window walks the seg1 splits and divides out
//   the sample point of each split with seg2 in range. Empty requests skip it.
// Throughput: one item at a time; the next item is taken the cycle after the
//   result moves into the output register.
// Reset: configuration registers return to their defaults, no result is pending.
// ----------------------------------------------------------------------------
module can_bit_timing_solver_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [cbts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbts_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cbts_pkg::BITRATE_W-1:0]  bus_rate,
	input  logic [cbts_pkg::POINT_W-1:0]    target_point,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            found,
	output logic [cbts_pkg::PRESC_W-1:0]    prescaler,
	output logic [cbts_pkg::SEG1_W-1:0]     seg1,
	output logic [cbts_pkg::SEG2_W-1:0]     seg2,
	output logic [cbts_pkg::JW_W-1:0]       jump_width,
	output logic [cbts_pkg::TQ_W-1:0]       quanta_per_bit,
	output logic [cbts_pkg::POINT_W-1:0]    point_achieved,
	output logic [cbts_pkg::BITRATE_W-1:0]  bitrate_achieved
);
	import cbts_pkg::*;

	cfg_t cfg_q;
	res_t res, out_q;
	logic out_valid_q;
	logic idle, res_valid, res_take, start;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_hz       <= CLOCK_RST;
			cfg_q.prescaler_min  <= PRESC_MIN_RST;
			cfg_q.prescaler_max  <= PRESC_MAX_RST;
			cfg_q.seg1_max       <= SEG1_MAX_RST;
			cfg_q.seg2_max       <= SEG2_MAX_RST;
			cfg_q.jump_width_max <= JW_MAX_RST;
			cfg_q.quanta_min     <= TQ_MIN_RST;
			cfg_q.quanta_max     <= TQ_MAX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CLOCK_HZ:       cfg_q.clock_hz       <= cfg_data[CLOCK_W-1:0];
				CFG_PRESCALER_MIN:  cfg_q.prescaler_min  <= cfg_data[PRESC_W-1:0];
				CFG_PRESCALER_MAX:  cfg_q.prescaler_max  <= cfg_data[PRESC_W-1:0];
				CFG_SEG1_MAX:       cfg_q.seg1_max       <= cfg_data[SEG1_W-1:0];
				CFG_SEG2_MAX:       cfg_q.seg2_max       <= cfg_data[SEG2_W-1:0];
				CFG_JUMP_WIDTH_MAX: cfg_q.jump_width_max <= cfg_data[JW_W-1:0];
				CFG_QUANTA_MIN:     cfg_q.quanta_min     <= cfg_data[TQ_W-1:0];
				CFG_QUANTA_MAX:     cfg_q.quanta_max     <= cfg_data[TQ_W-1:0];
				default: ;
			endcase
		end
	end

	// take an item only while the search is idle
	assign in_stall = ~idle;
	assign start    = in_valid & idle;

	cbts_search u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.bus_rate     (bus_rate),
		.target_point (target_point),
		.cfg          (cfg_q),
		.idle         (idle),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res)
	);

	// move the result into the output register once it is free
	assign res_take = res_valid & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign out_valid        = out_valid_q;
	assign found            = out_q.found;
	assign prescaler        = out_q.prescaler;
	assign seg1             = out_q.seg1;
	assign seg2             = out_q.seg2;
	assign jump_width       = out_q.jump_width;
	assign quanta_per_bit   = out_q.quanta_per_bit;
	assign point_achieved   = out_q.point_achieved;
	assign bitrate_achieved = out_q.bitrate_achieved;

	// accepted item keeps the input side busy next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again while search runs");

	// found timing adds up to the quanta total
	a_seg_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |->
		(6'(seg1) + 6'(seg2) + 6'd1) == 6'(quanta_per_bit))
		else $error("segments do not add up to quanta per bit");

	// jump width lies between one and seg2
	a_jw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (jump_width != '0) && (4'(jump_width) <= seg2))
		else $error("jump width out of range");

	// nothing found gives an all-zero timing
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |->
		(prescaler == '0) && (quanta_per_bit == '0) && (bitrate_achieved == '0))
		else $error("timing fields set without a solution");

endmodule

// ===== hw/rtl/cbts_cmp_sub.sv =====
// ----------------------------------------------------------------------------
// cbts_cmp_sub: shared compare-and-subtract unit
// Forms a - b and flags a >= b; every division step of the solver runs here.
// ----------------------------------------------------------------------------
module cbts_cmp_sub (
	input  logic [cbts_pkg::SUB_W-1:0] a,
	input  logic [cbts_pkg::SUB_W-1:0] b,
	output logic [cbts_pkg::SUB_W-1:0] diff,
	output logic                       ge
);
	import cbts_pkg::*;

	logic [SUB_W:0] wide;

	// subtract with borrow out
	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[SUB_W-1:0];
	assign ge   = ~wide[SUB_W];

endmodule

// ===== hw/rtl/cbts_search.sv =====
// ----------------------------------------------------------------------------
// cbts_search: prescaler and segment search sequencer
// Walks the prescaler range, finds exact quanta counts by restoring division,
// walks the seg1 splits, divides out the sample point and keeps the best.
// ----------------------------------------------------------------------------
module cbts_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cbts_pkg::BITRATE_W-1:0] bus_rate,
	input  logic [cbts_pkg::POINT_W-1:0]   target_point,
	input  cbts_pkg::cfg_t                 cfg,
	output logic                           idle,
	output logic                           res_valid,
	input  logic                           res_take,
	output cbts_pkg::res_t                 res
);
	import cbts_pkg::*;

	state_t state_q, state_d;

	// working registers
	logic [BITRATE_W-1:0] bitrate_q;
	logic [POINT_W-1:0]   target_q;
	logic [PRESC_W-1:0]   brp_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [REM_W-1:0]     rem_q;
	logic [POINT_W-1:0]   quo_q;
	logic [STEP_W-1:0]    step_q;
	logic [TQ_W-1:0]      tq_q;
	logic [CNT_W-1:0]     s1_q;

	// best candidate so far
	logic                 found_q;
	logic [POINT_W-1:0]   best_err_q;
	logic [TQ_W-1:0]      best_tq_q;
	logic [PRESC_W-1:0]   best_brp_q;
	logic [SEG1_W-1:0]    best_s1_q;
	logic [SEG2_W-1:0]    best_s2_q;
	logic [JW_W-1:0]      best_jw_q;
	logic [POINT_W-1:0]   best_sp_q;

	// shared unit
	logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
	logic             sub_ge;

	// derived values
	logic                 empty_req;
	logic                 tq_ok;
	logic                 seg_live;
	logic [TQ_W-1:0]      s2;
	logic                 s2_ok;
	logic [REM_W-1:0]     numer;
	logic [POINT_W-1:0]   err;
	logic                 better;
	logic [TQ_W-1:0]      jw_a, jw_b;
	logic [JW_W-1:0]      jw;

	cbts_cmp_sub u_cmp_sub (
		.a    (sub_a),
		.b    (sub_b),
		.diff (sub_diff),
		.ge   (sub_ge)
	);

	// request and loop conditions
	assign empty_req = (cfg.clock_hz == '0) || (bitrate_q == '0) ||
		(cfg.prescaler_min > cfg.prescaler_max);
	assign tq_ok = (rem_q == '0) && (quo_q[TQ_W-1:0] >= cfg.quanta_min) &&
		(quo_q[TQ_W-1:0] <= cfg.quanta_max);
	assign seg_live = (s1_q <= {1'b0, cfg.seg1_max}) &&
		((s1_q + CNT_W'(1)) < {1'b0, tq_q});
	assign s2    = tq_q - TQ_W'(1) - s1_q[TQ_W-1:0];
	assign s2_ok = (s2 >= TQ_W'(SEG2_MIN)) && (s2 <= {1'b0, cfg.seg2_max});
	assign numer = REM_W'((16'(s1_q) + 16'd1) * 16'(PERMILLE));

	// ranking of the sample point just divided out
	assign err    = (quo_q >= target_q) ? (quo_q - target_q) : (target_q - quo_q);
	assign better = !found_q || (err < best_err_q) ||
		((err == best_err_q) && (tq_q > best_tq_q));

	// jump width: min of seg2, limit and seg1, at least one
	assign jw_a = (s2 < {2'b0, cfg.jump_width_max}) ? s2 : {2'b0, cfg.jump_width_max};
	assign jw_b = (jw_a > s1_q[TQ_W-1:0]) ? s1_q[TQ_W-1:0] : jw_a;
	assign jw   = (jw_b == '0) ? JW_W'(1) : jw_b[JW_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_START;
			ST_START: state_d = empty_req ? ST_DONE : ST_MUL;
			ST_MUL:   state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == STEP_W'(TQ_STEPS) && sub_ge) state_d = ST_NEXT;
				else if (step_q == '0)                     state_d = ST_TQCHK;
			end
			ST_TQCHK: state_d = tq_ok ? ST_SEG : ST_NEXT;
			ST_SEG: begin
				if (!seg_live)  state_d = ST_NEXT;
				else if (s2_ok) state_d = ST_SPDIV;
			end
			ST_SPDIV: if (step_q == '0) state_d = ST_EVAL;
			ST_EVAL:  state_d = ST_SEG;
			ST_NEXT:  state_d = (brp_q == cfg.prescaler_max) ? ST_DONE : ST_MUL;
			ST_DONE:  if (res_take) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and shared unit operands
	always_comb begin
		idle      = 1'b0;
		res_valid = 1'b0;
		sub_a     = {{(SUB_W-REM_W){1'b0}}, rem_q};
		sub_b     = '0;
		unique case (state_q)
			ST_IDLE:  idle = 1'b1;
			ST_DIV:   sub_b = {{TQ_W{1'b0}}, div_q} << step_q;
			ST_SPDIV: sub_b = {{(SUB_W-TQ_W){1'b0}}, tq_q} << step_q;
			ST_DONE:  res_valid = 1'b1;
			default: ;
		endcase
	end

	// result fields, zero when nothing found
	always_comb begin
		res = '0;
		if (found_q) begin
			res.found            = 1'b1;
			res.prescaler        = best_brp_q;
			res.seg1             = best_s1_q;
			res.seg2             = best_s2_q;
			res.jump_width       = best_jw_q;
			res.quanta_per_bit   = best_tq_q;
			res.point_achieved   = best_sp_q;
			res.bitrate_achieved = bitrate_q;  // clock / (brp * tq) is exact
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					bitrate_q <= bus_rate;
					target_q  <= target_point;
					found_q   <= 1'b0;
				end
			end
			ST_START: begin
				brp_q <= cfg.prescaler_min;
			end
			ST_MUL: begin
				// full-width product of prescaler and bitrate
				div_q  <= DIVISOR_W'(brp_q) * DIVISOR_W'(bitrate_q);
				rem_q  <= cfg.clock_hz;
				step_q <= STEP_W'(TQ_STEPS);
			end
			ST_DIV: begin
				// top step only screens quotients of 32 and up
				if (step_q != STEP_W'(TQ_STEPS)) begin
					quo_q <= {quo_q[POINT_W-2:0], sub_ge};
					if (sub_ge) rem_q <= sub_diff[REM_W-1:0];
				end
				step_q <= step_q - STEP_W'(1);
			end
			ST_TQCHK: begin
				tq_q <= quo_q[TQ_W-1:0];
				s1_q <= CNT_W'(SEG1_MIN);
			end
			ST_SEG: begin
				// load the sample point numerator or skip this split
				if (seg_live && s2_ok) begin
					rem_q  <= numer;
					step_q <= STEP_W'(SP_STEPS - 1);
				end else begin
					s1_q <= s1_q + CNT_W'(1);
				end
			end
			ST_SPDIV: begin
				quo_q  <= {quo_q[POINT_W-2:0], sub_ge};
				if (sub_ge) rem_q <= sub_diff[REM_W-1:0];
				step_q <= step_q - STEP_W'(1);
			end
			ST_EVAL: begin
				if (better) begin
					found_q    <= 1'b1;
					best_err_q <= err;
					best_tq_q  <= tq_q;
					best_brp_q <= brp_q;
					best_s1_q  <= s1_q[SEG1_W-1:0];
					best_s2_q  <= s2[SEG2_W-1:0];
					best_jw_q  <= jw;
					best_sp_q  <= quo_q;
				end
				s1_q <= s1_q + CNT_W'(1);
			end
			ST_NEXT: begin
				brp_q <= brp_q + PRESC_W'(1);
			end
			default: ;
		endcase
	end

	// sample point divide only runs on a split below the total
	a_sp_split: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPDIV |-> (s1_q + CNT_W'(1)) < {1'b0, tq_q})
		else $error("sample point divide on an invalid split");

	// sample point quotient stays below one full bit
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL |-> quo_q < POINT_W'(PERMILLE))
		else $error("sample point out of range");

	// stored best candidate is self consistent
	a_best_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && state_q == ST_DONE) |->
		(6'(best_s1_q) + 6'(best_s2_q) + 6'd1) == 6'(best_tq_q))
		else $error("best candidate segments do not add up");

endmodule
